/* rtl/core/fuap_pkg.sv */
// Shared types and constants for the H.264 FU-A packetizer.
// Used by fuap_core, fuap_obuf and h264_fu_a_packetizer; no dependencies.
`default_nettype none

package fuap_pkg;

	// Longest NAL unit accepted; longer lengths are clamped to this value
	localparam int unsigned MAX_NAL_BYTES = 65535;
	localparam logic [15:0] NAL_LEN_CAP =
		(MAX_NAL_BYTES >= 65535) ? 16'hffff : 16'(MAX_NAL_BYTES);

	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1400;
	localparam logic [15:0] MIN_PAYLOAD     = 16'd3;

	// NAL header fields and FU-A codes
	localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
	localparam logic [7:0] NAL_NRI_MASK  = 8'h60;
	localparam logic [7:0] FU_A_TYPE     = 8'd28;
	localparam logic [4:0] TYPE_LIMIT    = 5'd24;
	localparam logic [7:0] FU_START_BIT  = 8'h80;
	localparam logic [7:0] FU_END_BIT    = 8'h40;

	// Error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_LIMIT = 2'd1;
	localparam logic [1:0] ERR_EMPTY = 2'd2;
	localparam logic [1:0] ERR_TYPE  = 2'd3;

	// Number of result words one input causes
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_FRAG = 2'd3;

	// One result word
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       packet_start;
		logic       packet_end;
		logic       marker;
		logic [1:0] error_code;
		logic       last_of_run;
	} word_t;

	// All result words caused by one input word
	typedef struct packed {
		logic [1:0] cnt;
		word_t      w2;
		word_t      w1;
		word_t      w0;
	} group_t;

endpackage

`default_nettype wire

/* rtl/core/h264_fu_a_packetizer.sv */
// Top level of the H.264 RTP packetizer (single NAL and FU-A modes).
// Depends on fuap_pkg, fuap_core and fuap_obuf.
//
//  Channel   Direction  Contents (low bit first)
//  s_axis    in         tdata: data_byte[7:0], nal_bytes[23:8]; tlast: unit_last_nal
//  m_axis    out        tdata: payload_byte; tuser: start, end, marker, error_code;
//                       tlast: last_of_run
//  cfg       in         cfg_we / cfg_wdata: max_payload_bytes
//
// One input word per cycle while the input side is not held; each word yields zero, one or three result words.
// A word that opens a fragment holds the input side while the result register
// sends indicator, header and data byte.
// An input word passes the input register and then the result register before its first result.
// Reset clears all NAL state; max_payload_bytes returns to 1400.
// Back-pressure on m_axis stalls the result register, then the input register.
`default_nettype none

module h264_fu_a_packetizer
	import fuap_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // data_byte[7:0], nal_bytes[23:8]
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // payload_byte[7:0]
	output logic [4:0]       m_axis_tuser,   // start[0], end[1], marker[2], error_code[4:3]
	output logic             m_axis_tlast
);

	logic [15:0] max_payload_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [15:0] len_s1;
	logic        ulast_s1;
	logic        load_ok, take;
	group_t      grp;
	word_t       out_word;

	// Payload limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	// Input register
	assign take          = valid_s1 && load_ok;
	assign s_axis_tready = !valid_s1 || load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata[7:0];
			len_s1   <= s_axis_tdata[23:8];
			ulast_s1 <= s_axis_tlast;
		end
	end

	fuap_core u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.max_payload_bytes (max_payload_q),
		.take              (take),
		.data_byte         (byte_s1),
		.nal_bytes         (len_s1),
		.unit_last_nal     (ulast_s1),
		.grp               (grp)
	);

	fuap_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp       (grp),
		.load      (take && (grp.cnt != CNT_NONE)),
		.load_ok   (load_ok),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (out_word)
	);

	// Output packing
	assign m_axis_tdata = out_word.payload_byte;
	assign m_axis_tuser = {out_word.error_code, out_word.marker,
		out_word.packet_end, out_word.packet_start};
	assign m_axis_tlast = out_word.last_of_run;

endmodule

`default_nettype wire

/* rtl/core/fuap_core.sv */
// Packetizer step logic: NAL/fragment state and result computation per word.
// Depends on fuap_pkg.
`default_nettype none

module fuap_core
	import fuap_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] max_payload_bytes,
	input  wire logic        take,
	input  wire logic [7:0]  data_byte,
	input  wire logic [15:0] nal_bytes,
	input  wire logic        unit_last_nal,
	output group_t           grp
);

	logic [15:0] nal_offset_q, frag_pos_q;
	logic [7:0]  fu_ind_q;
	logic [4:0]  orig_type_q;
	logic        fragmenting_q, dropping_q;

	logic [15:0] nal_offset_n, frag_pos_n;
	logic [7:0]  fu_ind_n;
	logic [4:0]  orig_type_n;
	logic        fragmenting_n, dropping_n;

	logic [15:0] len, cap;
	logic [4:0]  nal_type;
	logic        nal_end, unit_end, frag_end, first_frag, last_frag;
	logic [1:0]  err;
	logic [7:0]  fu_hdr;

	// Length clamp, end-of-NAL / end-of-fragment tests, FU header and error code
	always_comb begin
		len      = (nal_bytes > NAL_LEN_CAP) ? NAL_LEN_CAP : nal_bytes;
		nal_end  = ({1'b0, nal_offset_q} + 17'd1) >= {1'b0, len};
		unit_end = nal_end && unit_last_nal;
		nal_type = 5'(data_byte & NAL_TYPE_MASK);
		cap      = (max_payload_bytes >= MIN_PAYLOAD) ? (max_payload_bytes - 16'd2) : 16'd1;
		frag_end = nal_end || (({1'b0, frag_pos_q} + 17'd1) >= {1'b0, cap});
		first_frag = (nal_offset_q == 16'd1);
		last_frag  = (nal_offset_q >= len) || ((len - nal_offset_q) <= cap);
		fu_hdr = {3'b000, orig_type_q} | (first_frag ? FU_START_BIT : 8'h00)
			| (last_frag ? FU_END_BIT : 8'h00);
		if (max_payload_bytes < MIN_PAYLOAD) begin
			err = ERR_LIMIT;
		end else if (len == 16'd0) begin
			err = ERR_EMPTY;
		end else if ((nal_type == 5'd0) || (nal_type >= TYPE_LIMIT)) begin
			err = ERR_TYPE;
		end else begin
			err = ERR_NONE;
		end
	end

	// Results and next state for the word being taken
	always_comb begin
		nal_offset_n  = nal_offset_q;
		frag_pos_n    = frag_pos_q;
		fu_ind_n      = fu_ind_q;
		orig_type_n   = orig_type_q;
		fragmenting_n = fragmenting_q;
		dropping_n    = dropping_q;
		grp           = '0;

		priority if (dropping_q) begin
			if (unit_end) begin
				dropping_n = 1'b0;
			end
		end else if (nal_offset_q == 16'd0) begin
			priority if (err != ERR_NONE) begin
				grp.cnt            = CNT_ONE;
				grp.w0.error_code  = err;
				grp.w0.last_of_run = 1'b1;
				if (!unit_end) begin
					dropping_n = 1'b1;
				end
			end else if (len <= max_payload_bytes) begin
				fragmenting_n       = 1'b0;
				grp.cnt             = CNT_ONE;
				grp.w0.payload_byte = data_byte;
				grp.w0.packet_start = 1'b1;
				grp.w0.packet_end   = nal_end;
				grp.w0.marker       = unit_end;
				grp.w0.last_of_run  = 1'b1;
			end else begin
				fragmenting_n = 1'b1;
				fu_ind_n      = (data_byte & NAL_NRI_MASK) | FU_A_TYPE;
				orig_type_n   = nal_type;
				frag_pos_n    = 16'd0;
			end
		end else if (!fragmenting_q) begin
			grp.cnt             = CNT_ONE;
			grp.w0.payload_byte = data_byte;
			grp.w0.packet_end   = nal_end;
			grp.w0.marker       = unit_end;
			grp.w0.last_of_run  = 1'b1;
		end else begin
			if (frag_pos_q == 16'd0) begin
				// indicator, header, then the data byte
				grp.cnt             = CNT_FRAG;
				grp.w0.payload_byte = fu_ind_q;
				grp.w0.packet_start = 1'b1;
				grp.w1.payload_byte = fu_hdr;
				grp.w2.payload_byte = data_byte;
				grp.w2.packet_end   = frag_end;
				grp.w2.marker       = unit_end;
				grp.w2.last_of_run  = 1'b1;
			end else begin
				grp.cnt             = CNT_ONE;
				grp.w0.payload_byte = data_byte;
				grp.w0.packet_end   = frag_end;
				grp.w0.marker       = unit_end;
				grp.w0.last_of_run  = 1'b1;
			end
			frag_pos_n = frag_end ? 16'd0 : (frag_pos_q + 16'd1);
		end

		if (nal_end) begin
			nal_offset_n  = 16'd0;
			frag_pos_n    = 16'd0;
			fragmenting_n = 1'b0;
		end else begin
			nal_offset_n = nal_offset_q + 16'd1;
		end
	end

	// State registers, updated once per taken word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nal_offset_q  <= '0;
			frag_pos_q    <= '0;
			fu_ind_q      <= '0;
			orig_type_q   <= '0;
			fragmenting_q <= 1'b0;
			dropping_q    <= 1'b0;
		end else if (take) begin
			nal_offset_q  <= nal_offset_n;
			frag_pos_q    <= frag_pos_n;
			fu_ind_q      <= fu_ind_n;
			orig_type_q   <= orig_type_n;
			fragmenting_q <= fragmenting_n;
			dropping_q    <= dropping_n;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/fuap_obuf.sv */
// Result register: holds the words of one input and sends them one by one.
// Depends on fuap_pkg.
`default_nettype none

module fuap_obuf
	import fuap_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire group_t grp,
	input  wire logic   load,
	output logic        load_ok,
	output logic        out_valid,
	input  wire logic   out_ready,
	output word_t       out_word
);

	word_t      words_q [3];
	logic [1:0] cnt_q, idx_q;
	logic       busy_q;
	logic       at_last;

	assign at_last   = (idx_q == (cnt_q - 2'd1));
	assign load_ok   = !busy_q || (out_ready && at_last);
	assign out_valid = busy_q;
	assign out_word  = words_q[idx_q];

	// Control: word index and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= CNT_NONE;
			idx_q  <= 2'd0;
			busy_q <= 1'b0;
		end else if (load_ok) begin
			busy_q <= load;
			cnt_q  <= grp.cnt;
			idx_q  <= 2'd0;
		end else if (out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// Payload words
	always_ff @(posedge clk) begin
		if (load_ok && load) begin
			words_q[0] <= grp.w0;
			words_q[1] <= grp.w1;
			words_q[2] <= grp.w2;
		end
	end

endmodule

`default_nettype wire
